FILE: hw/rtl/gfpva_pkg.sv
// Shared types, widths and constant helpers for the GF(p) projective vector action block.
// No dependencies; every other file in hw/rtl imports this package.
package gfpva_pkg;

  localparam int ELEM_W           = 5;
  localparam int VEC_W            = 60;
  localparam int KEY_W            = 51;
  localparam int ROW_IDX_W        = 4;
  localparam int PROD_W           = 2 * ELEM_W;
  localparam int TBL_DEPTH        = 2 ** ELEM_W;
  localparam int DIMENSION_DEF    = 12;
  localparam int MODULUS_DEF      = 19;
  localparam int NUM_MATRICES_DEF = 2;
  // Number of register stages from the input register to the output register.
  localparam int NUM_STAGES       = 12;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_APPLY = 1'b1
  } opcode_t;

  // Weight of position pos in the key, base^pos kept modulo 2^KEY_W.
  function automatic logic [KEY_W-1:0] key_weight(input int pos, input int base);
    logic [KEY_W-1:0] w;
    w = KEY_W'(1);
    for (int k = 0; k < pos; k++) begin
      w = KEY_W'(w * KEY_W'(base));
    end
    return w;
  endfunction

endpackage

FILE: hw/rtl/gfpva_mod.sv
// Two-stage reduction of an unsigned value modulo the field order.
// Uses gfpva_pkg; a reciprocal multiply estimates the quotient, one subtract corrects it.
module gfpva_mod
  import gfpva_pkg::*;
#(
  parameter int IN_W    = PROD_W,
  parameter int MODULUS = MODULUS_DEF
) (
  input  logic              clk,
  input  logic [1:0]        stage_en,
  input  logic [IN_W-1:0]   in_val,
  output logic [ELEM_W-1:0] out_res
);

  // floor(2^IN_W / p) keeps the quotient estimate at most one below the true quotient.
  localparam logic [IN_W-1:0] RECIP = IN_W'((64'd1 << IN_W) / MODULUS);
  localparam logic [IN_W-1:0] P_W   = IN_W'(MODULUS);

  logic [IN_W-1:0]   val_r;
  logic [IN_W-1:0]   quot_r;
  logic [ELEM_W-1:0] res_r;
  logic [2*IN_W-1:0] qprod;
  logic [IN_W-1:0]   rem_raw;
  logic [IN_W-1:0]   rem_fix;

  assign qprod   = {{IN_W{1'b0}}, in_val} * {{IN_W{1'b0}}, RECIP};
  assign rem_raw = val_r - IN_W'(quot_r * P_W);
  assign rem_fix = (rem_raw >= P_W) ? (rem_raw - P_W) : rem_raw;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      val_r  <= in_val;
      quot_r <= qprod[2*IN_W-1:IN_W];
    end
    if (stage_en[1]) begin
      res_r <= ELEM_W'(rem_fix);
    end
  end

  assign out_res = res_r;

endmodule

FILE: hw/rtl/gfpva_lane.sv
// One column lane: dot product of the vector with one matrix column, reduced mod p.
// Uses gfpva_pkg and gfpva_mod; four register stages.
module gfpva_lane
  import gfpva_pkg::*;
#(
  parameter int DIMENSION = DIMENSION_DEF,
  parameter int MODULUS   = MODULUS_DEF
) (
  input  logic              clk,
  input  logic [3:0]        stage_en,
  input  logic [ELEM_W-1:0] vec_x [DIMENSION],
  input  logic [ELEM_W-1:0] col   [DIMENSION],
  output logic [ELEM_W-1:0] lane_res
);

  localparam int SUM_W = PROD_W + $clog2(DIMENSION);

  logic [PROD_W-1:0] prod_r [DIMENSION];
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  sum_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int i = 0; i < DIMENSION; i++) begin
        prod_r[i] <= PROD_W'(vec_x[i]) * PROD_W'(col[i]);
      end
    end
    if (stage_en[1]) begin
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < DIMENSION; i++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[i]);
    end
  end

  gfpva_mod #(
    .IN_W    (SUM_W),
    .MODULUS (MODULUS)
  ) u_mod (
    .clk      (clk),
    .stage_en (stage_en[3:2]),
    .in_val   (sum_r),
    .out_res  (lane_res)
  );

endmodule

FILE: hw/rtl/gfpva_norm.sv
// Merge stage: finds the leading nonzero element, looks up its inverse and rescales all lanes.
// Uses gfpva_pkg and gfpva_mod; four register stages.
module gfpva_norm
  import gfpva_pkg::*;
#(
  parameter int DIMENSION = DIMENSION_DEF,
  parameter int MODULUS   = MODULUS_DEF
) (
  input  logic              clk,
  input  logic [3:0]        stage_en,
  input  logic [ELEM_W-1:0] lane_res [DIMENSION],
  output logic [ELEM_W-1:0] norm_elem [DIMENSION],
  output logic              norm_zero
);

  logic [ELEM_W-1:0] inv_term [TBL_DEPTH][TBL_DEPTH];
  logic [ELEM_W-1:0] inv_tbl  [TBL_DEPTH];
  logic [DIMENSION-1:0] nz;
  logic [DIMENSION-1:0] first_oh;
  logic [ELEM_W-1:0]    lead;

  logic [ELEM_W-1:0] val_r [DIMENSION];
  logic [ELEM_W-1:0] scale_r;
  logic              zero6_r;
  logic [PROD_W-1:0] mul_r [DIMENSION];
  logic              zero7_r;
  logic              zero8_r;
  logic              zero9_r;

  // Inverse table built at elaboration; entries with no inverse stay zero.
  for (genvar gv = 0; gv < TBL_DEPTH; gv++) begin : g_inv_v
    for (genvar gc = 0; gc < TBL_DEPTH; gc++) begin : g_inv_c
      assign inv_term[gv][gc] = (gv < MODULUS && gc >= 1 && gc < MODULUS &&
                                 ((gv * gc) % MODULUS) == 1) ? ELEM_W'(gc) : '0;
    end
  end

  always_comb begin
    for (int v = 0; v < TBL_DEPTH; v++) begin
      inv_tbl[v] = '0;
      for (int c = 0; c < TBL_DEPTH; c++) begin
        inv_tbl[v] = inv_tbl[v] | inv_term[v][c];
      end
    end
  end

  // Isolate the lowest set bit of the nonzero mask to pick the leading element.
  always_comb begin
    for (int j = 0; j < DIMENSION; j++) begin
      nz[j] = (lane_res[j] != '0);
    end
    first_oh = nz & (~nz + DIMENSION'(1));
    lead = '0;
    for (int j = 0; j < DIMENSION; j++) begin
      lead = lead | (first_oh[j] ? lane_res[j] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      val_r   <= lane_res;
      scale_r <= inv_tbl[lead];
      zero6_r <= ~|nz;
    end
    if (stage_en[1]) begin
      for (int j = 0; j < DIMENSION; j++) begin
        mul_r[j] <= PROD_W'(val_r[j]) * PROD_W'(scale_r);
      end
      zero7_r <= zero6_r;
    end
    if (stage_en[2]) begin
      zero8_r <= zero7_r;
    end
    if (stage_en[3]) begin
      zero9_r <= zero8_r;
    end
  end

  for (genvar gj = 0; gj < DIMENSION; gj++) begin : g_scale
    gfpva_mod #(
      .IN_W    (PROD_W),
      .MODULUS (MODULUS)
    ) u_mod (
      .clk      (clk),
      .stage_en (stage_en[3:2]),
      .in_val   (mul_r[gj]),
      .out_res  (norm_elem[gj])
    );
  end

  assign norm_zero = zero9_r;

endmodule

FILE: hw/rtl/gfpva_key.sv
// Packs the normalized image and forms its base-p key through a registered adder tree.
// Uses gfpva_pkg; three register stages, the last one is the output register.
module gfpva_key
  import gfpva_pkg::*;
#(
  parameter int DIMENSION = DIMENSION_DEF,
  parameter int MODULUS   = MODULUS_DEF
) (
  input  logic              clk,
  input  logic [2:0]        stage_en,
  input  logic [ELEM_W-1:0] norm_elem [DIMENSION],
  input  logic              norm_zero,
  output logic [VEC_W-1:0]  image,
  output logic [KEY_W-1:0]  key,
  output logic              zero_flag
);

  localparam int GROUPS = (DIMENSION + 3) / 4;

  logic [KEY_W-1:0] weight [DIMENSION];
  logic [KEY_W-1:0] term_r [DIMENSION];
  logic [VEC_W-1:0] image_nxt;
  logic [VEC_W-1:0] image10_r;
  logic [VEC_W-1:0] image11_r;
  logic [VEC_W-1:0] image12_r;
  logic             zero10_r;
  logic             zero11_r;
  logic             zero12_r;
  logic [KEY_W-1:0] grp_nxt [GROUPS];
  logic [KEY_W-1:0] grp_r   [GROUPS];
  logic [KEY_W-1:0] key_nxt;
  logic [KEY_W-1:0] key_r;

  for (genvar gj = 0; gj < DIMENSION; gj++) begin : g_weight
    assign weight[gj] = key_weight(gj, MODULUS);
  end

  always_comb begin
    image_nxt = '0;
    for (int j = 0; j < DIMENSION; j++) begin
      image_nxt[ELEM_W*j +: ELEM_W] = norm_elem[j];
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < 4; k++) begin
        if (4 * g + k < DIMENSION) begin
          grp_nxt[g] = grp_nxt[g] + term_r[4*g+k];
        end
      end
    end
    key_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      key_nxt = key_nxt + grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int j = 0; j < DIMENSION; j++) begin
        term_r[j] <= KEY_W'(KEY_W'(norm_elem[j]) * weight[j]);
      end
      image10_r <= image_nxt;
      zero10_r  <= norm_zero;
    end
    if (stage_en[1]) begin
      grp_r     <= grp_nxt;
      image11_r <= image10_r;
      zero11_r  <= zero10_r;
    end
    if (stage_en[2]) begin
      key_r     <= key_nxt;
      image12_r <= image11_r;
      zero12_r  <= zero11_r;
    end
  end

  assign image     = image12_r;
  assign key       = key_r;
  assign zero_flag = zero12_r;

endmodule

FILE: hw/rtl/gf_p_projective_vector_action.sv
// An accepted apply item's result shows after the input register, lane, merge and key stages.
// Throughput: one item per cycle while out_ready is high; each stage moves when the next one is empty or moving.
// Load items with a row index below DIMENSION write a matrix row at acceptance; no load item produces a result.
// rst_n (synchronous, active low) empties the pipeline; stored matrix rows are not cleared.
// Uses gfpva_pkg, gfpva_lane, gfpva_norm and gfpva_key.
module gf_p_projective_vector_action
  import gfpva_pkg::*;
#(
  parameter int DIMENSION    = DIMENSION_DEF,
  parameter int MODULUS      = MODULUS_DEF,
  parameter int NUM_MATRICES = NUM_MATRICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic                 in_generator_select,
  input  logic [ROW_IDX_W-1:0] in_row_index,
  input  logic [VEC_W-1:0]     in_vector_elements,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VEC_W-1:0]     out_image_elements,
  output logic [KEY_W-1:0]     out_point_key,
  output logic                 out_zero_image
);

  localparam int MSEL_W = (NUM_MATRICES > 1) ? $clog2(NUM_MATRICES) : 1;
  localparam int ROW_W  = $clog2(DIMENSION);

  logic [ELEM_W-1:0] mod_tbl [TBL_DEPTH];
  logic [ELEM_W-1:0] in_x    [DIMENSION];
  logic [MSEL_W-1:0] sel_idx;
  logic              accept;
  logic              apply_acc;
  logic              load_acc;

  logic [NUM_STAGES:1]   valid_r;
  logic [NUM_STAGES+1:1] adv;

  logic [ELEM_W-1:0] mat_r [NUM_MATRICES][DIMENSION][DIMENSION];
  logic [ELEM_W-1:0] x_r   [DIMENSION];
  logic [MSEL_W-1:0] sel_r;
  logic [ELEM_W-1:0] lane_res  [DIMENSION];
  logic [ELEM_W-1:0] norm_elem [DIMENSION];
  logic              norm_zero;

  for (genvar gv = 0; gv < TBL_DEPTH; gv++) begin : g_mod_tbl
    assign mod_tbl[gv] = ELEM_W'(gv % MODULUS);
  end

  always_comb begin
    for (int i = 0; i < DIMENSION; i++) begin
      in_x[i] = mod_tbl[in_vector_elements[ELEM_W*i +: ELEM_W]];
    end
  end

  assign sel_idx   = (NUM_MATRICES == 1) ? '0 : MSEL_W'(in_generator_select);
  assign accept    = in_valid && in_ready;
  assign apply_acc = accept && (in_opcode == OP_APPLY);
  assign load_acc  = accept && (in_opcode == OP_LOAD);

  // A stage may load when it is empty or its item moves on in the same cycle.
  always_comb begin
    adv[NUM_STAGES+1] = out_ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[1]) begin
        valid_r[1] <= apply_acc;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // A row write lands on the same edge that an earlier item reads the matrix, so
  // that item still sees the old contents.
  always_ff @(posedge clk) begin
    if (load_acc && (in_row_index < ROW_IDX_W'(DIMENSION))) begin
      mat_r[sel_idx][in_row_index[ROW_W-1:0]] <= in_x;
    end
    if (adv[1]) begin
      x_r   <= in_x;
      sel_r <= sel_idx;
    end
  end

  for (genvar gj = 0; gj < DIMENSION; gj++) begin : g_lane
    logic [ELEM_W-1:0] col [DIMENSION];

    always_comb begin
      for (int i = 0; i < DIMENSION; i++) begin
        col[i] = mat_r[sel_r][i][gj];
      end
    end

    gfpva_lane #(
      .DIMENSION (DIMENSION),
      .MODULUS   (MODULUS)
    ) u_lane (
      .clk      (clk),
      .stage_en (adv[5:2]),
      .vec_x    (x_r),
      .col      (col),
      .lane_res (lane_res[gj])
    );
  end

  gfpva_norm #(
    .DIMENSION (DIMENSION),
    .MODULUS   (MODULUS)
  ) u_norm (
    .clk       (clk),
    .stage_en  (adv[9:6]),
    .lane_res  (lane_res),
    .norm_elem (norm_elem),
    .norm_zero (norm_zero)
  );

  gfpva_key #(
    .DIMENSION (DIMENSION),
    .MODULUS   (MODULUS)
  ) u_key (
    .clk       (clk),
    .stage_en  (adv[12:10]),
    .norm_elem (norm_elem),
    .norm_zero (norm_zero),
    .image     (out_image_elements),
    .key       (out_point_key),
    .zero_flag (out_zero_image)
  );

  assign out_valid = valid_r[NUM_STAGES];

endmodule

FILE: hw/rtl/gfpva_checker.sv
// Port-level checks for gf_p_projective_vector_action, attached to it by the bind below.
// Uses gfpva_pkg for field widths.
module gfpva_checker
  import gfpva_pkg::*;
#(
  parameter int DIMENSION = DIMENSION_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VEC_W-1:0] out_image_elements,
  input logic [KEY_W-1:0] out_point_key,
  input logic             out_zero_image
);

  localparam int USED_W = ELEM_W * DIMENSION;

  // A result that is not taken stays on the outputs unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_image_elements) &&
      $stable(out_point_key) && $stable(out_zero_image))
    else $error("result changed while stalled");

  // The input side only stalls when every stage is full and the output is blocked.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // A zero product gives an all-zero image and key.
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_image |-> out_image_elements == '0 && out_point_key == '0)
    else $error("zero image with nonzero payload");

  // Positions past the dimension are always zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_image_elements >> USED_W) == '0)
    else $error("image element beyond the dimension is set");

endmodule

bind gf_p_projective_vector_action gfpva_checker #(.DIMENSION(DIMENSION)) u_gfpva_checker (.*);
